FILE: rtl/core/kt3d_pkg.sv
package kt3d_pkg;

    localparam int AXES = 3;

    // input kinds
    localparam logic [1:0] KIND_INIT = 2'd0;
    localparam logic [1:0] KIND_PRED = 2'd1;
    localparam logic [1:0] KIND_UPD  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_STEP_TIME  = 3'd0;
    localparam logic [2:0] CFG_ACCEL_VAR  = 3'd1;
    localparam logic [2:0] CFG_MEAS_VAR   = 3'd2;
    localparam logic [2:0] CFG_START_X    = 3'd3;
    localparam logic [2:0] CFG_START_Y    = 3'd4;
    localparam logic [2:0] CFG_START_Z    = 3'd5;

    localparam logic [15:0] STEP_TIME_RST = 16'd655;
    localparam logic [31:0] VAR_RST       = 32'd65536;
    localparam logic signed [47:0] ONE_Q24 = 48'sd16777216;

    // datapath operations
    typedef logic [4:0] t_op;
    localparam t_op OP_NOP   = 5'd0;
    localparam t_op OP_LATCH = 5'd1;
    localparam t_op OP_INIT  = 5'd2;
    localparam t_op OP_D2M   = 5'd3;
    localparam t_op OP_D2W   = 5'd4;
    localparam t_op OP_D3M   = 5'd5;
    localparam t_op OP_D3W   = 5'd6;
    localparam t_op OP_D4M   = 5'd7;
    localparam t_op OP_D4W   = 5'd8;
    localparam t_op OP_QPPM  = 5'd9;
    localparam t_op OP_QPVM  = 5'd10;
    localparam t_op OP_QVVM  = 5'd11;
    localparam t_op OP_QVVW  = 5'd12;
    localparam t_op OP_TM    = 5'd13;
    localparam t_op OP_TW    = 5'd14;
    localparam t_op OP_PVW   = 5'd15;
    localparam t_op OP_TTW   = 5'd16;
    localparam t_op OP_VW    = 5'd17;
    localparam t_op OP_AD2W  = 5'd18;
    localparam t_op OP_ADTW  = 5'd19;
    localparam t_op OP_DIVGO = 5'd20;
    localparam t_op OP_UM1   = 5'd21;
    localparam t_op OP_UW1   = 5'd22;
    localparam t_op OP_UPPL  = 5'd23;
    localparam t_op OP_UPPH  = 5'd24;
    localparam t_op OP_UPVL  = 5'd25;
    localparam t_op OP_UPVH  = 5'd26;
    localparam t_op OP_UVVL  = 5'd27;
    localparam t_op OP_UVVH  = 5'd28;
    localparam t_op OP_UEND  = 5'd29;
    localparam t_op OP_SAVE  = 5'd30;
    localparam t_op OP_OUT   = 5'd31;

    localparam logic [3:0] PRE_LAST = 4'd9;
    localparam logic [3:0] AXP_LAST = 4'd7;
    localparam logic [3:0] UPD_LAST = 4'd9;
    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [4:0] DIV_STEPS = 5'd31;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic s_bad;
        logic out_free;
    } t_status;

    // floor((x + 2^(n-1)) / 2^n)
    function automatic logic signed [65:0] f_rnd(input logic signed [65:0] x,
                                                input int unsigned n);
        logic signed [66:0] s;
        s = {x[65], x} + (67'sd1 <<< (n - 1));
        return 66'(s >>> n);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [43:0] x);
        if (&x[43:31] || ~|x[43:31])
            return x[31:0];
        return x[43] ? 32'sh80000000 : 32'sh7FFFFFFF;
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [55:0] x);
        if (&x[55:47] || ~|x[55:47])
            return x[47:0];
        return x[55] ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
    endfunction

endpackage

FILE: rtl/core/kt3d_intf.sv
interface kt3d_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    modport source (output valid, kind, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, kind, vec_x, vec_y, vec_z, output ready);
endinterface

interface kt3d_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface kt3d_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/kt3d_div.sv
module kt3d_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [47:0]        i_mag,
    input  logic               i_neg,
    input  logic [47:0]        i_den,
    output logic signed [31:0] o_quot,
    output logic               o_done
);
    import kt3d_pkg::*;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [47:0] r_rem;
    logic [30:0] r_low;
    logic [30:0] r_q;
    logic        r_sat;
    logic        r_neg;
    logic [47:0] r_den;

    logic [48:0] trial;
    logic        ge;
    logic [48:0] diff;
    logic [30:0] qmag;

    // one quotient bit per cycle, mag*2^24 / den
    assign trial = {r_rem, r_low[30]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_STEPS;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1)
                r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {7'b0, i_mag[47:7]};
            r_low <= {i_mag[6:0], 24'b0};
            r_q   <= '0;
            r_sat <= {7'b0, i_mag} >= {i_den, 7'b0};
            r_neg <= i_neg;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[47:0] : trial[47:0];
            r_q   <= {r_q[29:0], ge};
            r_low <= {r_low[29:0], 1'b0};
        end
    end

    assign qmag   = r_sat ? 31'h7FFFFFFF : r_q;
    assign o_quot = r_neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    assign o_done = !r_busy;

endmodule

FILE: rtl/core/kt3d_ctrl.sv
module kt3d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_kind,
    input  kt3d_pkg::t_status i_status,
    output logic              o_in_ready,
    output kt3d_pkg::t_cmd    o_cmd
);
    import kt3d_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRE  = 3'd1;
    localparam logic [2:0] ST_AXP  = 3'd2;
    localparam logic [2:0] ST_AXU  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_INIT = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_kind, n_kind;
    t_op        op;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_axis     = r_axis;
        n_kind     = r_kind;
        op         = OP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    op     = OP_LATCH;
                    n_kind = i_kind;
                    n_axis = '0;
                    n_step = '0;
                    case (i_kind)
                        KIND_INIT: n_state = ST_INIT;
                        KIND_PRED: n_state = ST_PRE;
                        KIND_UPD:  n_state = ST_AXU;
                        default:   n_state = ST_OUT;
                    endcase
                end
            end
            ST_INIT: begin
                op      = OP_INIT;
                n_state = ST_OUT;
            end
            ST_PRE: begin
                op = OP_D2M + {1'b0, r_step};
                if (r_step == PRE_LAST) begin
                    n_step  = '0;
                    n_state = ST_AXP;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_AXP: begin
                if (r_step == AXP_LAST) begin
                    op     = OP_SAVE;
                    n_step = '0;
                    if (r_axis == AXIS_LAST)
                        n_state = ST_OUT;
                    else
                        n_axis = r_axis + 2'd1;
                end else begin
                    op     = OP_TM + {1'b0, r_step};
                    n_step = r_step + 4'd1;
                end
            end
            ST_AXU: begin
                // axis with nonpositive innovation variance is left alone
                if (i_status.s_bad) begin
                    if (r_axis == AXIS_LAST)
                        n_state = ST_OUT;
                    else
                        n_axis = r_axis + 2'd1;
                end else begin
                    op      = OP_DIVGO;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_step  = '0;
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (r_step == UPD_LAST) begin
                    op     = OP_SAVE;
                    n_step = '0;
                    if (r_axis == AXIS_LAST) begin
                        n_state = ST_OUT;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = ST_AXU;
                    end
                end else begin
                    op     = OP_UM1 + {1'b0, r_step};
                    n_step = r_step + 4'd1;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    op      = OP_OUT;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_axis  <= '0;
            r_kind  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_axis  <= n_axis;
            r_kind  <= n_kind;
        end
    end

    assign o_cmd.op   = op;
    assign o_cmd.axis = r_axis;

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis != 2'd3)
        else $error("axis counter out of range");

    a_div_only_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_kind == KIND_UPD)
        else $error("divider wait outside update");

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op == OP_OUT |=> r_state == ST_IDLE)
        else $error("result word issued but not idle");

endmodule

FILE: rtl/core/kt3d_dp.sv
module kt3d_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kt3d_pkg::t_cmd     i_cmd,
    output kt3d_pkg::t_status  o_status,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z
);
    import kt3d_pkg::*;

    logic [15:0]        r_dt;
    logic [31:0]        r_q;
    logic [31:0]        r_r;
    logic signed [31:0] r_start [AXES];

    logic signed [31:0] r_pos [AXES];
    logic signed [31:0] r_vel [AXES];
    logic signed [47:0] r_pp  [AXES];
    logic signed [47:0] r_pv  [AXES];
    logic signed [47:0] r_vv  [AXES];
    logic signed [31:0] r_vec [AXES];

    logic [31:0]        r_d2, r_d3, r_d4;
    logic [39:0]        r_qpp, r_qpv, r_qvv;
    logic signed [47:0] r_t;
    logic signed [43:0] r_np, r_nv;
    logic signed [55:0] r_npp, r_npv, r_nvv, r_acc;
    logic signed [32:0] r_y;
    logic signed [65:0] r_prod;

    logic               r_out_valid;
    logic signed [31:0] r_out [AXES];

    logic [1:0]         ax;
    logic signed [31:0] cur_p, cur_v, cur_a;
    logic signed [47:0] cur_pp, cur_pv, cur_vv;
    logic signed [16:0] dtx;

    logic signed [47:0] ma_a;
    logic signed [16:0] ma_b;
    logic signed [32:0] mb_a, mb_b;
    logic               use_a;
    logic signed [64:0] prod_a;
    logic signed [65:0] prod_b;

    logic signed [49:0] s_full;
    logic signed [31:0] kp, kv;
    logic               kp_done, kv_done;
    logic [47:0]        mag_pp, mag_pv;

    assign ax     = i_cmd.axis;
    assign cur_p  = r_pos[ax];
    assign cur_v  = r_vel[ax];
    assign cur_a  = r_vec[ax];
    assign cur_pp = r_pp[ax];
    assign cur_pv = r_pv[ax];
    assign cur_vv = r_vv[ax];
    assign dtx    = {1'b0, r_dt};

    // innovation variance pp + r
    assign s_full = 50'(cur_pp) + $signed({10'b0, r_r, 8'b0});
    assign mag_pp = cur_pp[47] ? 48'(-cur_pp) : cur_pp;
    assign mag_pv = cur_pv[47] ? 48'(-cur_pv) : cur_pv;

    kt3d_div u_div_kp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIVGO),
        .i_mag   (mag_pp),
        .i_neg   (cur_pp[47]),
        .i_den   (s_full[47:0]),
        .o_quot  (kp),
        .o_done  (kp_done)
    );

    kt3d_div u_div_kv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIVGO),
        .i_mag   (mag_pv),
        .i_neg   (cur_pv[47]),
        .i_den   (s_full[47:0]),
        .o_quot  (kv),
        .o_done  (kv_done)
    );

    assign o_status.div_done = kp_done && kv_done;
    assign o_status.s_bad    = s_full[49] || (s_full == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // multiplier operand select
    always_comb begin
        ma_a  = '0;
        ma_b  = dtx;
        mb_a  = '0;
        mb_b  = '0;
        use_a = 1'b0;
        case (i_cmd.op)
            OP_D2M: begin ma_a = 48'(r_dt); use_a = 1'b1; end
            OP_D3M: begin ma_a = {16'b0, r_d2}; use_a = 1'b1; end
            OP_D4M: begin ma_a = {16'b0, r_d3}; use_a = 1'b1; end
            OP_QPPM: begin mb_a = {1'b0, r_q}; mb_b = {1'b0, r_d4}; end
            OP_QPVM: begin mb_a = {1'b0, r_q}; mb_b = {1'b0, r_d3}; end
            OP_QVVM: begin mb_a = {1'b0, r_q}; mb_b = {1'b0, r_d2}; end
            OP_TM:  begin ma_a = cur_vv; use_a = 1'b1; end
            OP_TW:  begin ma_a = cur_pv; use_a = 1'b1; end
            OP_PVW: begin ma_a = r_t; use_a = 1'b1; end
            OP_TTW: begin mb_a = 33'(cur_v); mb_b = 33'(dtx); end
            OP_VW:  begin mb_a = 33'(cur_a); mb_b = {1'b0, r_d2}; end
            OP_AD2W: begin mb_a = 33'(cur_a); mb_b = 33'(dtx); end
            OP_UM1: begin mb_a = 33'(kp); mb_b = r_y; end
            OP_UW1: begin mb_a = 33'(kv); mb_b = r_y; end
            OP_UPPL: begin mb_a = 33'(kp); mb_b = {9'b0, cur_pp[23:0]}; end
            OP_UPPH: begin mb_a = 33'(kp); mb_b = 33'(cur_pp[47:24]); end
            OP_UPVL: begin mb_a = 33'(kp); mb_b = {9'b0, cur_pv[23:0]}; end
            OP_UPVH: begin mb_a = 33'(kp); mb_b = 33'(cur_pv[47:24]); end
            OP_UVVL: begin mb_a = 33'(kv); mb_b = {9'b0, cur_pv[23:0]}; end
            OP_UVVH: begin mb_a = 33'(kv); mb_b = 33'(cur_pv[47:24]); end
            default: ;
        endcase
    end

    assign prod_a = ma_a * ma_b;
    assign prod_b = mb_a * mb_b;

    always_ff @(posedge i_clk) begin
        r_prod <= use_a ? 66'(prod_a) : prod_b;
        case (i_cmd.op)
            OP_D2W:  r_d2  <= r_prod[31:0];
            OP_D3W:  r_d3  <= 32'(f_rnd(r_prod, 16));
            OP_D4W:  r_d4  <= 32'(f_rnd(r_prod, 16));
            OP_QPVM: r_qpp <= 40'(f_rnd(r_prod, 26));
            OP_QVVM: r_qpv <= 40'(f_rnd(r_prod, 25));
            OP_QVVW: r_qvv <= 40'(f_rnd(r_prod, 24));
            OP_TM: begin
                r_np  <= 44'(cur_p);
                r_nv  <= 44'(cur_v);
                r_npp <= 56'(cur_pp) + $signed({16'b0, r_qpp});
                r_npv <= 56'(cur_pv) + $signed({16'b0, r_qpv});
                r_nvv <= 56'(cur_vv) + $signed({16'b0, r_qvv});
            end
            OP_TW:  r_t <= 48'(f_rnd(r_prod, 16));
            OP_PVW: begin
                r_npp <= r_npp + 56'(f_rnd(r_prod, 15));
                r_npv <= r_npv + 56'(r_t);
            end
            OP_TTW:  r_npp <= r_npp + 56'(f_rnd(r_prod, 16));
            OP_VW:   r_np  <= r_np + 44'(f_rnd(r_prod, 16));
            OP_AD2W: r_np  <= r_np + 44'(f_rnd(r_prod, 33));
            OP_ADTW: r_nv  <= r_nv + 44'(f_rnd(r_prod, 16));
            OP_DIVGO: r_y  <= {cur_a[31], cur_a} - {cur_p[31], cur_p};
            OP_UM1: begin
                r_np  <= 44'(cur_p);
                r_nv  <= 44'(cur_v);
                r_npp <= 56'(cur_pp);
                r_npv <= 56'(cur_pv);
                r_nvv <= 56'(cur_vv);
            end
            OP_UW1:  r_np  <= r_np + 44'(f_rnd(r_prod, 24));
            OP_UPPL: r_nv  <= r_nv + 44'(f_rnd(r_prod, 24));
            OP_UPPH: r_acc <= 56'(f_rnd(r_prod, 24));
            // gain times the high half is exact, low half already rounded
            OP_UPVL: r_npp <= r_npp - (r_acc + 56'(r_prod));
            OP_UPVH: r_acc <= 56'(f_rnd(r_prod, 24));
            OP_UVVL: r_npv <= r_npv - (r_acc + 56'(r_prod));
            OP_UVVH: r_acc <= 56'(f_rnd(r_prod, 24));
            OP_UEND: r_nvv <= r_nvv - (r_acc + 56'(r_prod));
            OP_LATCH: begin
                r_vec[0] <= i_vec_x;
                r_vec[1] <= i_vec_y;
                r_vec[2] <= i_vec_z;
            end
            default: ;
        endcase
    end

    // config registers, tracker state and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt        <= STEP_TIME_RST;
            r_q         <= VAR_RST;
            r_r         <= VAR_RST;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_start[i] <= '0;
                r_pos[i]   <= '0;
                r_vel[i]   <= '0;
                r_pp[i]    <= ONE_Q24;
                r_pv[i]    <= '0;
                r_vv[i]    <= ONE_Q24;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEP_TIME: r_dt       <= i_cfg_data[15:0];
                    CFG_ACCEL_VAR: r_q        <= i_cfg_data;
                    CFG_MEAS_VAR:  r_r        <= i_cfg_data;
                    CFG_START_X:   r_start[0] <= i_cfg_data;
                    CFG_START_Y:   r_start[1] <= i_cfg_data;
                    CFG_START_Z:   r_start[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_INIT: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_pos[i] <= r_start[i];
                        r_vel[i] <= '0;
                        r_pp[i]  <= ONE_Q24;
                        r_pv[i]  <= '0;
                        r_vv[i]  <= ONE_Q24;
                    end
                end
                OP_SAVE: begin
                    r_pos[ax] <= f_sat32(r_np);
                    r_vel[ax] <= f_sat32(r_nv);
                    r_pp[ax]  <= f_sat48(r_npp);
                    r_pv[ax]  <= f_sat48(r_npv);
                    r_vv[ax]  <= f_sat48(r_nvv);
                end
                default: ;
            endcase
            if (i_cmd.op == OP_OUT)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            for (int i = 0; i < AXES; i++)
                r_out[i] <= r_pos[i];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out[0];
    assign o_pos_y     = r_out[1];
    assign o_pos_z     = r_out[2];

endmodule

FILE: rtl/core/kalman_tracker_3d_const_velocity_unit.sv
// channel  dir  fields                      word accepted when
// i_in     in   kind, vec_x, vec_y, vec_z    valid && ready
// o_out    out  pos_x, pos_y, pos_z          valid && ready
// i_cfg    in   index, data                  valid && ready (ready always high)
//
// one word in process at a time; input ready only while the sequencer is idle
// update: one gain divide for each axis with positive innovation variance
// (the two gains of an axis divide side by side)
// synchronous active-low reset restores the register defaults and the
// identity covariance; a held result stalls only the final hand-off
module kalman_tracker_3d_const_velocity_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kt3d_in_if.sink     i_in,
    kt3d_out_if.source  o_out,
    kt3d_cfg_if.sink    i_cfg
);
    import kt3d_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    kt3d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    kt3d_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_vec_x     (i_in.vec_x),
        .i_vec_y     (i_in.vec_y),
        .i_vec_z     (i_in.vec_z),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_pos_x     (o_out.pos_x),
        .o_pos_y     (o_out.pos_y),
        .o_pos_z     (o_out.pos_z)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

endmodule
